FILE: rtl/btr_pkg.sv
// Shared types and constants of the bus event trace ring.
`default_nettype none
package btr_pkg;

  localparam int CAP_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int AGE_W      = 10;
  localparam logic [CAP_W-1:0] CAP_MAX = 11'h7FF;

  localparam logic [1:0] OP_IO    = 2'd0;
  localparam logic [1:0] OP_MEM   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] K_REC   = 2'd0;
  localparam logic [1:0] K_READ  = 2'd1;
  localparam logic [1:0] K_CLEAR = 2'd2;
  localparam logic [1:0] K_SKIP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILT0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILT1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILT2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILT3 = 3'd4;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             is_mem;
    logic             is_read;
    logic [15:0]      addr;
    logic [7:0]       data;
    logic [15:0]      pc;
    logic [31:0]      frame;
    logic [15:0]      line;
    logic [15:0]      pixel;
    logic [31:0]      cycle;
    logic [AGE_W-1:0] age;
  } cmd_t;

  typedef struct packed {
    logic [31:0] frame;
    logic [31:0] cycle;
    logic [15:0] addr;
    logic [15:0] pc;
    logic [15:0] line;
    logic [15:0] pixel;
    logic [7:0]  data;
    logic        is_read;
    logic        is_mem;
  } ent_t;

  typedef struct packed {
    logic             hit;
    logic             is_read;
    logic             is_mem;
    logic [15:0]      addr;
    logic [7:0]       data;
    logic [15:0]      pc;
    logic [31:0]      frame;
    logic [15:0]      line;
    logic [15:0]      pixel;
    logic [31:0]      cycle;
    logic [CAP_W-1:0] count;
    logic             wrapped;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/btr_ifs.sv
// Valid/ready channel interfaces for bus events and trace results.
`default_nettype none
interface btr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        is_read_access;
  logic [15:0] bus_address;
  logic [7:0]  data_byte;
  logic [15:0] program_counter;
  logic [31:0] frame_number;
  logic [15:0] scan_line;
  logic [15:0] pixel_pos;
  logic [31:0] cycle_stamp;
  logic [9:0]  age_index;

  modport source (
    output valid, opcode, is_read_access, bus_address, data_byte, program_counter,
           frame_number, scan_line, pixel_pos, cycle_stamp, age_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, is_read_access, bus_address, data_byte, program_counter,
           frame_number, scan_line, pixel_pos, cycle_stamp, age_index,
    output ready
  );
endinterface

interface btr_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        ev_is_read;
  logic        ev_is_memory;
  logic [15:0] ev_address;
  logic [7:0]  ev_data;
  logic [15:0] ev_pc;
  logic [31:0] ev_frame;
  logic [15:0] ev_scanline;
  logic [15:0] ev_pixel;
  logic [31:0] ev_cycle;
  logic [10:0] entry_count;
  logic        wrapped;

  modport source (
    output valid, hit, ev_is_read, ev_is_memory, ev_address, ev_data, ev_pc,
           ev_frame, ev_scanline, ev_pixel, ev_cycle, entry_count, wrapped,
    input  ready
  );
  modport sink (
    input  valid, hit, ev_is_read, ev_is_memory, ev_address, ev_data, ev_pc,
           ev_frame, ev_scanline, ev_pixel, ev_cycle, entry_count, wrapped,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/btr_front.sv
// Front end: accepts bus events, applies the I/O port filter, builds commands.
`default_nettype none
module btr_front
  import btr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_wr_t cfg,
  btr_in_if.sink       in_ch,
  input  wire logic    q_full,
  output logic         push,
  output cmd_t         cmd
);

  logic [CFG_DATA_W-1:0] filt_r [4];
  logic [7:0]            low_byte;
  logic                  port_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) filt_r[i] <= '1;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_FILT0: filt_r[0] <= cfg.data;
        CFG_FILT1: filt_r[1] <= cfg.data;
        CFG_FILT2: filt_r[2] <= cfg.data;
        CFG_FILT3: filt_r[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  assign low_byte    = in_ch.bus_address[7:0];
  assign port_ok     = filt_r[low_byte[7:6]][low_byte[5:0]];
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    cmd.is_mem  = 1'b0;
    cmd.is_read = in_ch.is_read_access;
    cmd.addr    = in_ch.bus_address;
    cmd.data    = in_ch.data_byte;
    cmd.pc      = in_ch.program_counter;
    cmd.frame   = in_ch.frame_number;
    cmd.line    = in_ch.scan_line;
    cmd.pixel   = in_ch.pixel_pos;
    cmd.cycle   = in_ch.cycle_stamp;
    cmd.age     = in_ch.age_index;
    case (in_ch.opcode)
      OP_IO:    cmd.kind = port_ok ? K_REC : K_SKIP;
      OP_MEM: begin
        cmd.kind   = K_REC;
        cmd.is_mem = 1'b1;
      end
      OP_READ:  cmd.kind = K_READ;
      OP_CLEAR: cmd.kind = K_CLEAR;
      default:  cmd.kind = K_SKIP;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/btr_queue.sv
// Two-entry command queue between the front and back ends.
`default_nettype none
module btr_queue
  import btr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      full,
  output logic      empty
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_cmd = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/btr_back.sv
// Back end: ring pointers, trace memory, entry lookup and result register.
`default_nettype none
module btr_back
  import btr_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_wr_t cfg,
  input  wire logic    q_empty,
  input  wire cmd_t    q_cmd,
  output logic         pop,
  btr_out_if.source    out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = (AW + 1 > 12) ? AW + 1 : 12;
  localparam logic [CAP_W-1:0] DEPTH_CAP = (DEPTH > 2047) ? CAP_MAX : CAP_W'(DEPTH);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  ent_t mem [DEPTH];
  ent_t mem_q;
  ent_t wr_ent;

  logic [AW-1:0]    head_r, head_nxt;
  logic [CAP_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             ovf_r, ovf_nxt;
  logic             state_r, state_nxt;
  logic             rd_hit_r, rd_hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;
  res_t             res_base;

  logic             wr_en, rd_en, slot_free, read_hit;
  logic [SW-1:0]    head_inc, cap_ext, age_ext, sum, phys;
  logic [CAP_W-1:0] cap_wr, cap_clamp;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop       = (state_r == ST_IDLE) && !q_empty && slot_free;
  assign head_inc  = SW'(head_r) + SW'(1);
  assign cap_ext   = SW'(cap_r);
  assign age_ext   = SW'(q_cmd.age);
  assign sum       = SW'(head_r) + age_ext;
  assign phys      = !ovf_r ? age_ext : ((sum >= cap_ext) ? sum - cap_ext : sum);
  assign read_hit  = ({1'b0, q_cmd.age} < count_r);
  assign cap_wr    = cfg.data[CAP_W-1:0];
  assign cap_clamp = (cap_wr == '0) ? CAP_W'(1) :
                     ((32'(cap_wr) > 32'(DEPTH)) ? DEPTH_CAP : cap_wr);

  always_comb begin
    wr_ent.frame   = q_cmd.frame;
    wr_ent.cycle   = q_cmd.cycle;
    wr_ent.addr    = q_cmd.addr;
    wr_ent.pc      = q_cmd.pc;
    wr_ent.line    = q_cmd.line;
    wr_ent.pixel   = q_cmd.pixel;
    wr_ent.data    = q_cmd.data;
    wr_ent.is_read = q_cmd.is_read;
    wr_ent.is_mem  = q_cmd.is_mem;
  end

  always_comb begin
    res_base         = '0;
    res_base.count   = count_r;
    res_base.wrapped = ovf_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    cap_nxt       = cap_r;
    state_nxt     = state_r;
    rd_hit_nxt    = rd_hit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    if (state_r == ST_RD) begin
      out_nxt         = res_base;
      out_nxt.hit     = rd_hit_r;
      if (rd_hit_r) begin
        out_nxt.is_read = mem_q.is_read;
        out_nxt.is_mem  = mem_q.is_mem;
        out_nxt.addr    = mem_q.addr;
        out_nxt.data    = mem_q.data;
        out_nxt.pc      = mem_q.pc;
        out_nxt.frame   = mem_q.frame;
        out_nxt.line    = mem_q.line;
        out_nxt.pixel   = mem_q.pixel;
        out_nxt.cycle   = mem_q.cycle;
      end
      out_valid_nxt = 1'b1;
      state_nxt     = ST_IDLE;
    end else if (pop) begin
      case (q_cmd.kind)
        K_REC: begin
          wr_en    = 1'b1;
          head_nxt = (head_inc >= cap_ext) ? '0 : head_inc[AW-1:0];
          if (count_r < cap_r) count_nxt = count_r + CAP_W'(1);
          else ovf_nxt = 1'b1;
          out_nxt         = '0;
          out_nxt.hit     = 1'b1;
          out_nxt.count   = count_nxt;
          out_nxt.wrapped = ovf_nxt;
          out_valid_nxt   = 1'b1;
        end
        K_READ: begin
          rd_en      = 1'b1;
          rd_hit_nxt = read_hit;
          state_nxt  = ST_RD;
        end
        K_CLEAR: begin
          head_nxt      = '0;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
        end
        K_SKIP: begin
          out_nxt       = res_base;
          out_valid_nxt = 1'b1;
        end
        default: begin
          out_nxt       = res_base;
          out_valid_nxt = 1'b1;
        end
      endcase
    end
    if (cfg.we && cfg.index == CFG_CAP) begin
      cap_nxt   = cap_clamp;
      head_nxt  = '0;
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[head_r] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_q <= mem[phys[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      cap_r       <= DEPTH_CAP;
      state_r     <= ST_IDLE;
      rd_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      cap_r       <= cap_nxt;
      state_r     <= state_nxt;
      rd_hit_r    <= rd_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_r.hit;
  assign out_ch.ev_is_read   = out_r.is_read;
  assign out_ch.ev_is_memory = out_r.is_mem;
  assign out_ch.ev_address   = out_r.addr;
  assign out_ch.ev_data      = out_r.data;
  assign out_ch.ev_pc        = out_r.pc;
  assign out_ch.ev_frame     = out_r.frame;
  assign out_ch.ev_scanline  = out_r.line;
  assign out_ch.ev_pixel     = out_r.pixel;
  assign out_ch.ev_cycle     = out_r.cycle;
  assign out_ch.entry_count  = out_r.count;
  assign out_ch.wrapped      = out_r.wrapped;

endmodule
`default_nettype wire

FILE: rtl/bus_event_trace_ring_core.sv
// Top level of the bus event trace ring.
//
// Usage: bus events and trace commands arrive on in_ch, one transaction each;
// every transaction yields exactly one result transaction on out_ch, in order.
// Opcodes record an I/O event (kept only if its port filter bit is set),
// record a memory event, read an entry by age (0 is oldest) or clear the ring.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle:
// index 0 sets the capacity in use (clamped to 1..DEPTH, and clears the ring),
// indexes 1 to 4 load the 64-bit port filter words.
// Records, skips and clears pass through the queue and the result register;
// reads also pass the registered memory read port. Records stream at one
// transaction per cycle while out_ch.ready stays high; a read holds the back
// end in its read state until its result is registered. A two-entry command
// queue separates the filter front end from the ring back end, and the front
// end keeps accepting while a result waits, until the queue fills.
// Reset empties the queue and the ring, sets the capacity to DEPTH and all
// filter bits to one. A stalled receiver holds the result steady and, once the
// queue is full, drops in_ch.ready.
`default_nettype none
module bus_event_trace_ring_core
  import btr_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  btr_in_if.sink                     in_ch,
  btr_out_if.source                  out_ch
);

  cfg_wr_t cfg;
  cmd_t    push_cmd, pop_cmd;
  logic    push, pop, q_full, q_empty;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  btr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  btr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  btr_back #(.DEPTH(DEPTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_cmd   (pop_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("command pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty) else $error("command popped from an empty queue");

  a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    pop && out_ch.valid |-> out_ch.ready)
    else $error("command taken while the result register is blocked");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid) else $error("result valid right after reset");

endmodule
`default_nettype wire

FILE: dv/bus_event_trace_ring_core_tb.sv
// Self-checking testbench for bus_event_trace_ring_core against a shadow trace ring.
`default_nettype none
import btr_pkg::*;

typedef struct packed {
  logic [1:0]  opcode;
  logic        is_read;
  logic [15:0] addr;
  logic [7:0]  data;
  logic [15:0] pc;
  logic [31:0] frame;
  logic [15:0] line;
  logic [15:0] pixel;
  logic [31:0] cycle;
  logic [9:0]  age;
} bus_txn_t;

class ring_shadow;
  localparam int RING_DEPTH = 1024;

  ent_t        slots [RING_DEPTH];
  int unsigned capacity;
  int unsigned head;
  int unsigned count;
  bit          overflowed;
  logic [63:0] port_mask [4];
  res_t        awaited_replies [$];
  int unsigned n_errors;
  int unsigned n_checked;
  int unsigned n_hits;
  int unsigned n_wrap_replies;

  function new();
    capacity = RING_DEPTH;
    foreach (port_mask[i]) port_mask[i] = '1;
    empty_ring();
  endfunction

  function void empty_ring();
    head = 0;
    count = 0;
    overflowed = 1'b0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    int unsigned v;
    case (idx)
      CFG_CAP: begin
        v = 32'(value[CAP_W-1:0]);
        if (v < 1) v = 1;
        if (v > RING_DEPTH) v = RING_DEPTH;
        capacity = v;
        empty_ring();
      end
      CFG_FILT0: port_mask[0] = value;
      CFG_FILT1: port_mask[1] = value;
      CFG_FILT2: port_mask[2] = value;
      CFG_FILT3: port_mask[3] = value;
      default: ;
    endcase
  endfunction

  function void store_event(bus_txn_t ev, bit is_mem);
    ent_t e;
    e.frame   = ev.frame;
    e.cycle   = ev.cycle;
    e.addr    = ev.addr;
    e.pc      = ev.pc;
    e.line    = ev.line;
    e.pixel   = ev.pixel;
    e.data    = ev.data;
    e.is_read = ev.is_read;
    e.is_mem  = is_mem;
    slots[head] = e;
    head = (head + 1 >= capacity) ? 0 : head + 1;
    if (count < capacity) count++;
    else overflowed = 1'b1;
  endfunction

  function void note_event(bus_txn_t ev);
    res_t        r;
    ent_t        e;
    int unsigned phys;
    logic [7:0]  port;
    r = '0;
    case (ev.opcode)
      OP_IO: begin
        port = ev.addr[7:0];
        if (port_mask[port[7:6]][port[5:0]]) begin
          store_event(ev, 1'b0);
          r.hit = 1'b1;
        end
      end
      OP_MEM: begin
        store_event(ev, 1'b1);
        r.hit = 1'b1;
      end
      OP_READ: begin
        if (ev.age < count) begin
          phys = 32'(ev.age);
          if (overflowed) begin
            phys = head + 32'(ev.age);
            if (phys >= capacity) phys -= capacity;
          end
          e = slots[phys];
          r.hit     = 1'b1;
          r.is_read = e.is_read;
          r.is_mem  = e.is_mem;
          r.addr    = e.addr;
          r.data    = e.data;
          r.pc      = e.pc;
          r.frame   = e.frame;
          r.line    = e.line;
          r.pixel   = e.pixel;
          r.cycle   = e.cycle;
        end
      end
      OP_CLEAR: empty_ring();
      default: ;
    endcase
    r.count   = CAP_W'(count);
    r.wrapped = overflowed;
    awaited_replies.push_back(r);
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch in result %0d, %s: expected %0h, got %0h",
                 n_checked, field, want, got);
    end
  endfunction

  function void check_reply(res_t got);
    res_t want;
    if (awaited_replies.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("result with nothing outstanding: hit %0b count %0d", got.hit, got.count);
      return;
    end
    want = awaited_replies.pop_front();
    n_checked++;
    if (want.hit) n_hits++;
    if (want.wrapped) n_wrap_replies++;
    compare("hit", want.hit, got.hit);
    compare("ev_is_read", want.is_read, got.is_read);
    compare("ev_is_memory", want.is_mem, got.is_mem);
    compare("ev_address", want.addr, got.addr);
    compare("ev_data", want.data, got.data);
    compare("ev_pc", want.pc, got.pc);
    compare("ev_frame", want.frame, got.frame);
    compare("ev_scanline", want.line, got.line);
    compare("ev_pixel", want.pixel, got.pixel);
    compare("ev_cycle", want.cycle, got.cycle);
    compare("entry_count", want.count, got.count);
    compare("wrapped", want.wrapped, got.wrapped);
  endfunction
endclass

module bus_event_trace_ring_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  btr_in_if  in_ch ();
  btr_out_if out_ch ();

  ring_shadow  shadow;
  cfg_wr_t     reg_writes [$];
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold_len;
  int unsigned n_sent;
  int unsigned n_phases;

  bus_event_trace_ring_core #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("bus_event_trace_ring_core_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold_len != 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_len = rx_hold_len - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.hit     = out_ch.hit;
      got.is_read = out_ch.ev_is_read;
      got.is_mem  = out_ch.ev_is_memory;
      got.addr    = out_ch.ev_address;
      got.data    = out_ch.ev_data;
      got.pc      = out_ch.ev_pc;
      got.frame   = out_ch.ev_frame;
      got.line    = out_ch.ev_scanline;
      got.pixel   = out_ch.ev_pixel;
      got.cycle   = out_ch.ev_cycle;
      got.count   = out_ch.entry_count;
      got.wrapped = out_ch.wrapped;
      shadow.check_reply(got);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bus_txn_t fixed_event(logic [1:0] op, bit ones, logic [15:0] addr,
                                           logic [9:0] age);
    bus_txn_t ev;
    ev = '0;
    if (ones) ev = '1;
    ev.opcode = op;
    ev.addr   = addr;
    ev.age    = age;
    return ev;
  endfunction

  function automatic bus_txn_t random_event();
    bus_txn_t    ev;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) ev.opcode = OP_IO;
    else if (pick < 60) ev.opcode = OP_MEM;
    else if (pick < 93) ev.opcode = OP_READ;
    else ev.opcode = OP_CLEAR;
    ev.is_read = 1'($urandom_range(0, 1));
    ev.addr    = 16'($urandom);
    ev.data    = 8'($urandom);
    ev.pc      = 16'($urandom);
    ev.frame   = $urandom;
    ev.line    = 16'($urandom);
    ev.pixel   = 16'($urandom);
    ev.cycle   = $urandom;
    ev.age     = 10'($urandom);
    if (ev.opcode == OP_READ && $urandom_range(0, 9) < 7)
      ev.age = 10'($urandom_range(0, shadow.count));
    return ev;
  endfunction

  function automatic void queue_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    reg_writes.push_back('{we: 1'b1, index: idx, data: value});
  endfunction

  task automatic send_event(bus_txn_t ev);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= ev.opcode;
    in_ch.is_read_access  <= ev.is_read;
    in_ch.bus_address     <= ev.addr;
    in_ch.data_byte       <= ev.data;
    in_ch.program_counter <= ev.pc;
    in_ch.frame_number    <= ev.frame;
    in_ch.scan_line       <= ev.line;
    in_ch.pixel_pos       <= ev.pixel;
    in_ch.cycle_stamp     <= ev.cycle;
    in_ch.age_index       <= ev.age;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    shadow.note_event(ev);
    n_sent++;
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) send_event(random_event());
  endtask

  task automatic pause_until_idle();
    in_ch.valid <= 1'b0;
    while (shadow.awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs();
    cfg_wr_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_we    <= 1'b1;
      cfg_index <= w.index;
      cfg_wdata <= w.data;
      @(posedge clk);
      shadow.write_reg(w.index, w.data);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic begin_phase(logic [CFG_DATA_W-1:0] cap, logic [63:0] f0, logic [63:0] f1,
                             logic [63:0] f2, logic [63:0] f3, int unsigned tx,
                             int unsigned rx);
    pause_until_idle();
    queue_write(CFG_CAP, cap);
    queue_write(CFG_FILT0, f0);
    queue_write(CFG_FILT1, f1);
    queue_write(CFG_FILT2, f2);
    queue_write(CFG_FILT3, f3);
    write_regs();
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    n_phases++;
  endtask

  initial begin
    shadow = new();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_len  = 0;
    n_sent       = 0;
    n_phases     = 0;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.opcode          <= OP_IO;
    in_ch.is_read_access  <= 1'b0;
    in_ch.bus_address     <= '0;
    in_ch.data_byte       <= '0;
    in_ch.program_counter <= '0;
    in_ch.frame_number    <= '0;
    in_ch.scan_line       <= '0;
    in_ch.pixel_pos       <= '0;
    in_ch.cycle_stamp     <= '0;
    in_ch.age_index       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: full capacity, every port enabled
    send_event(fixed_event(OP_READ, 1'b0, 16'h0000, 10'd0));
    send_event(fixed_event(OP_IO, 1'b0, 16'h0000, 10'd0));
    send_event(fixed_event(OP_MEM, 1'b1, 16'hFFFF, 10'h3FF));
    send_event(fixed_event(OP_IO, 1'b1, 16'h12FF, 10'd0));
    send_event(fixed_event(OP_READ, 1'b0, 16'h0000, 10'd0));
    send_event(fixed_event(OP_READ, 1'b1, 16'hFFFF, 10'd1));
    send_event(fixed_event(OP_READ, 1'b0, 16'h0000, 10'd2));
    send_event(fixed_event(OP_READ, 1'b0, 16'h0000, 10'd3));
    send_event(fixed_event(OP_READ, 1'b1, 16'hFFFF, 10'h3FF));
    send_event(fixed_event(OP_CLEAR, 1'b1, 16'hFFFF, 10'd0));
    send_event(fixed_event(OP_READ, 1'b0, 16'h0000, 10'd0));

    // capacity of zero clamps to one; sparse port filters; spare index dropped
    pause_until_idle();
    queue_write(CFG_CAP, '0);
    queue_write(CFG_FILT0, 64'h1);
    queue_write(CFG_FILT1, 64'h8000_0000_0000_0000);
    queue_write(CFG_FILT2, '0);
    queue_write(CFG_FILT3, '1);
    queue_write(CFG_SPARE, rand64());
    write_regs();
    n_phases++;
    send_event(fixed_event(OP_IO, 1'b0, 16'h0000, 10'd0));
    send_event(fixed_event(OP_IO, 1'b1, 16'hAB01, 10'd0));
    send_event(fixed_event(OP_IO, 1'b1, 16'h007F, 10'd0));
    send_event(fixed_event(OP_IO, 1'b1, 16'h0040, 10'd0));
    send_event(fixed_event(OP_IO, 1'b1, 16'h0080, 10'd0));
    send_event(fixed_event(OP_IO, 1'b1, 16'hFFFF, 10'd0));
    send_event(fixed_event(OP_READ, 1'b0, 16'h0000, 10'd0));
    send_event(fixed_event(OP_READ, 1'b0, 16'h0000, 10'd1));
    send_event(fixed_event(OP_MEM, 1'b0, 16'h0000, 10'd0));
    send_event(fixed_event(OP_CLEAR, 1'b0, 16'h0000, 10'd0));
    send_event(fixed_event(OP_READ, 1'b0, 16'h0000, 10'd0));

    begin_phase(11'h7FF, '1, rand64(), rand64(), '1, 0, 0);
    run_random(170);
    begin_phase(11'd3, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, rand64(), rand64(),
                51, 0);
    run_random(150);
    begin_phase(11'd1, '0, '0, rand64(), '1, 0, 51);
    run_random(150);
    begin_phase(11'd17, rand64(), rand64(), rand64(), rand64(), 24, 24);
    run_random(150);

    // hold off the receiver so that the block backs up its input
    begin_phase(11'd8, rand64(), rand64(), rand64(), rand64(), 0, 0);
    run_random(20);
    rx_hold_len = 300;
    run_random(60);
    pause_until_idle();
    run_random(100);

    begin_phase(11'd1024, '1, '1, '1, '1, 24, 24);
    run_random(150);

    pause_until_idle();
    repeat (16) @(posedge clk);
    shadow.n_errors += shadow.awaited_replies.size();
    $display("covered %0d transactions over %0d configurations, %0d results checked",
             n_sent, n_phases, shadow.n_checked);
    $display("%0d stored or found, %0d results seen with the ring overflowed",
             shadow.n_hits, shadow.n_wrap_replies);
    if (shadow.n_errors == 0) begin
      $display("bus_event_trace_ring_core_tb: done, clean");
    end else begin
      $display("bus_event_trace_ring_core_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/btr_pkg.sv
rtl/btr_ifs.sv
rtl/btr_front.sv
rtl/btr_queue.sv
rtl/btr_back.sv
rtl/bus_event_trace_ring_core.sv
dv/bus_event_trace_ring_core_tb.sv
